### src/affine2d_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 2D affine transform unit.
// No dependencies; imported by affine_2d_transform_unit_top.
package affine2d_pkg;

  localparam int DATA_W      = 32;              // Q-format word width
  localparam int COEF_W      = DATA_W + 1;      // elementary coefficient, holds -(-2^31)
  localparam int KIND_W      = 3;
  localparam int IN_TDATA_W  = 4 * DATA_W;      // arg_a, arg_b, point_x, point_y
  localparam int OUT_TDATA_W = 2 * DATA_W;      // out_x, out_y
  localparam int MAT_N       = 6;               // top two rows of the 3x3 matrix

  typedef enum logic [KIND_W-1:0] {
    KIND_POINT     = 3'd0,
    KIND_TRANSLATE = 3'd1,
    KIND_ROTATE    = 3'd2,
    KIND_SCALE     = 3'd3,
    KIND_SHEAR_X   = 3'd4,
    KIND_REFLECT_X = 3'd5,
    KIND_REFLECT_Y = 3'd6,
    KIND_RESET     = 3'd7
  } kind_t;

endpackage

### src/affine_2d_transform_unit_top.sv
`timescale 1ns / 1ps
// 2D affine transform unit: keeps a homogeneous 2x3 matrix, prepends
// elementary transforms to it and maps points through it.
// Depends on affine2d_pkg.
//
// Usage:
//   Input stream s_axis_*: tuser carries the item kind (point, translate,
//   rotate, scale, shear x, reflect x, reflect y, reset to identity);
//   tdata carries arg_a, arg_b, point_x, point_y, all signed Q(32-F).F.
//   Output stream m_axis_*: one transaction per point item, carrying the
//   mapped x and y, saturated to 32 bits. Other kinds give no output.
//   Timing: a transaction is captured in an input register; from there the
//   multiply, round and saturate logic either updates the matrix or loads
//   the output register. One item per cycle is sustained while no point
//   item is held by a stalled output, set by the single pass through the
//   parallel multipliers (twelve for matrix updates, four for points). A
//   matrix update is visible to the very next item.
//   Reset: rst (synchronous) empties both registers and loads the identity.
//   Stall: while m_axis_tready is low a pending result holds; a point item
//   behind it waits in the input register, and a non-point item still
//   retires, so input is taken as long as the input register can drain.
module affine_2d_transform_unit_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] arg_a, [63:32] arg_b, [95:64] point_x, [127:96] point_y
  input  logic [affine2d_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // [2:0] kind
  input  logic [affine2d_pkg::KIND_W-1:0]     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] out_x, [63:32] out_y
  output logic [affine2d_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import affine2d_pkg::*;

  localparam int PROD_W = 2 * COEF_W;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic [DATA_W-1:0]        ONE_W   = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [COEF_W-1:0] ONE_C   = $signed({1'b0, ONE_W});
  localparam logic signed [COEF_W-1:0] NEG_ONE = -ONE_C;
  localparam logic signed [PROD_W-1:0] HALF    = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [MAT_N-1:0][DATA_W-1:0] IDENT =
    {{DATA_W{1'b0}}, ONE_W, {DATA_W{1'b0}}, {DATA_W{1'b0}}, {DATA_W{1'b0}}, ONE_W};

  // product rounded to FRAC_BITS fraction bits, halves toward plus infinity
  function automatic logic signed [PROD_W-1:0] fx_mul(
    input logic signed [COEF_W-1:0] a,
    input logic signed [COEF_W-1:0] b
  );
    logic signed [PROD_W-1:0] p;
    p = a * b + HALF;
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic [DATA_W-1:0] sat_w(input logic signed [SUM_W-1:0] v);
    logic all0;
    logic all1;
    all0 = ~|v[SUM_W-1:DATA_W-1];
    all1 = &v[SUM_W-1:DATA_W-1];
    if (all0 || all1) begin
      return v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [COEF_W-1:0] sx(input logic [DATA_W-1:0] v);
    return $signed({v[DATA_W-1], v});
  endfunction

  // input register
  logic                in_valid;
  kind_t               kind_q;
  logic [DATA_W-1:0]   arg_a;
  logic [DATA_W-1:0]   arg_b;
  logic [DATA_W-1:0]   point_x;
  logic [DATA_W-1:0]   point_y;

  // matrix m00 m01 m02 m10 m11 m12 and output register
  logic [MAT_N-1:0][DATA_W-1:0] mat;
  logic [MAT_N-1:0][DATA_W-1:0] mat_next;
  logic                out_valid;
  logic [DATA_W-1:0]   out_x;
  logic [DATA_W-1:0]   out_y;
  logic [DATA_W-1:0]   out_x_next;
  logic [DATA_W-1:0]   out_y_next;

  logic                is_point;
  logic                adv;
  logic signed [COEF_W-1:0] t [MAT_N];
  logic signed [SUM_W-1:0]  sum_x;
  logic signed [SUM_W-1:0]  sum_y;

  assign is_point      = (kind_q == KIND_POINT);
  assign adv           = in_valid && (!is_point || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_y, out_x};

  // elementary matrix, top two rows
  always_comb begin
    t[0] = ONE_C;
    t[1] = '0;
    t[2] = '0;
    t[3] = '0;
    t[4] = ONE_C;
    t[5] = '0;
    case (kind_q)
      KIND_TRANSLATE: begin
        t[2] = sx(arg_a);
        t[5] = sx(arg_b);
      end
      KIND_ROTATE: begin
        t[0] = sx(arg_a);
        t[1] = -sx(arg_b);
        t[3] = sx(arg_b);
        t[4] = sx(arg_a);
      end
      KIND_SCALE: begin
        t[0] = sx(arg_a);
        t[4] = sx(arg_b);
      end
      KIND_SHEAR_X:   t[1] = sx(arg_a);
      KIND_REFLECT_X: t[4] = NEG_ONE;
      KIND_REFLECT_Y: t[0] = NEG_ONE;
      default: ;
    endcase
  end

  // new = T * M
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 3; j++) begin
        mat_next[i*3+j] = sat_w(SUM_W'(fx_mul(t[i*3], sx(mat[j])))
                              + SUM_W'(fx_mul(t[i*3+1], sx(mat[3+j])))
                              + ((j == 2) ? SUM_W'(t[i*3+2]) : SUM_W'(0)));
      end
    end
  end

  // point mapping
  always_comb begin
    sum_x = SUM_W'(fx_mul(sx(mat[0]), sx(point_x)))
          + SUM_W'(fx_mul(sx(mat[1]), sx(point_y)))
          + SUM_W'(sx(mat[2]));
    sum_y = SUM_W'(fx_mul(sx(mat[3]), sx(point_x)))
          + SUM_W'(fx_mul(sx(mat[4]), sx(point_y)))
          + SUM_W'(sx(mat[5]));
    out_x_next = sat_w(sum_x);
    out_y_next = sat_w(sum_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      kind_q  <= kind_t'(s_axis_tuser);
      arg_a   <= s_axis_tdata[DATA_W-1:0];
      arg_b   <= s_axis_tdata[2*DATA_W-1:DATA_W];
      point_x <= s_axis_tdata[3*DATA_W-1:2*DATA_W];
      point_y <= s_axis_tdata[4*DATA_W-1:3*DATA_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mat <= IDENT;
    end else if (adv && !is_point) begin
      if (kind_q == KIND_RESET) begin
        mat <= IDENT;
      end else begin
        mat <= mat_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && is_point) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (adv && is_point) begin
      out_x <= out_x_next;
      out_y <= out_y_next;
    end
  end

  a_reset_identity : assert property (@(posedge clk) disable iff (rst)
    adv && kind_q == KIND_RESET |=> mat == IDENT)
    else $error("matrix not identity after reset item");

  a_point_keeps_matrix : assert property (@(posedge clk) disable iff (rst)
    adv && is_point |=> $stable(mat))
    else $error("point item changed the matrix");

  a_point_result : assert property (@(posedge clk) disable iff (rst)
    adv && is_point |=> m_axis_tvalid && out_x == $past(out_x_next)
                        && out_y == $past(out_y_next))
    else $error("point result missing or wrong");

  a_no_spurious_result : assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(adv && is_point))
    else $error("result raised without a point item");

  a_input_held : assert property (@(posedge clk) disable iff (rst)
    in_valid && !adv |=> in_valid && $stable(kind_q) && $stable(point_x))
    else $error("blocked item lost from input register");

endmodule

### verif/tb_affine_2d_transform_unit_top.sv
`timescale 1ns / 1ps
// Self-checking bench for affine_2d_transform_unit_top: a directed table, then random
// matrix commands and point transactions under idle and back-pressure phases.
// Depends on affine2d_pkg and the unit under test.
module tb_affine_2d_transform_unit_top;
  import affine2d_pkg::*;

  localparam int FRAC        = 16;
  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYC   = 5;
  localparam int RAND_ITEMS  = 1500;
  localparam int PHASES      = 4;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYC   = 4;

  typedef struct {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } xy_t;

  typedef struct {
    kind_t       kind;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] x;
    logic [31:0] y;
    bit          typed;
    logic [31:0] ex;
    logic [31:0] ey;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [KIND_W-1:0]      s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  logic signed [DATA_W-1:0] xform_m [MAT_N];
  xy_t point_results_q [$];
  int  mismatch_count = 0;
  int  quiet_cycles   = 0;
  int  src_idle_pct   = 0;
  int  sink_stall_pct = 0;

  int idle_tab  [PHASES] = '{0, 78, 0, 27};
  int stall_tab [PHASES] = '{0, 0, 78, 27};

  // directed rows: identity, saturation, exact negated sine, rounding of halves, every kind
  stim_row_t dir_rows [25] = '{
    '{KIND_POINT,     32'h0, 32'h0, 32'h0001_0000, 32'hFFFE_0000,
      1'b1, 32'h0001_0000, 32'hFFFE_0000},
    '{KIND_POINT,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
      1'b1, 32'h7FFF_FFFF, 32'h8000_0000},
    '{KIND_TRANSLATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      1'b0, 32'h0, 32'h0},
    '{KIND_POINT,     32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
      1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
    '{KIND_RESET,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      1'b0, 32'h0, 32'h0},
    '{KIND_TRANSLATE, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0,
      1'b0, 32'h0, 32'h0},
    '{KIND_POINT,     32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000,
      1'b1, 32'h8000_0000, 32'h8000_0000},
    '{KIND_RESET,     32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
    '{KIND_ROTATE,    32'h0, 32'h0001_0000, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
    '{KIND_POINT,     32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000,
      1'b1, 32'hFFFE_0000, 32'h0001_0000},
    '{KIND_RESET,     32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
    '{KIND_ROTATE,    32'h0, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
    '{KIND_POINT,     32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0, 32'h0},
    '{KIND_RESET,     32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
    '{KIND_SCALE,     32'h0000_8000, 32'h0000_8000, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
    '{KIND_POINT,     32'h0, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF,
      1'b1, 32'h0000_0001, 32'h0000_0000},
    '{KIND_SCALE,     32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
    '{KIND_POINT,     32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
    '{KIND_RESET,     32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
    '{KIND_SHEAR_X,   32'h0002_0000, 32'h1234_5678, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
    '{KIND_REFLECT_X, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
    '{KIND_REFLECT_Y, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
    '{KIND_POINT,     32'h0, 32'h0, 32'h0003_0000, 32'h0001_0000, 1'b0, 32'h0, 32'h0},
    '{KIND_ROTATE,    32'h0000_B505, 32'h0000_B505, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
    '{KIND_POINT,     32'h0, 32'h0, 32'h0005_8000, 32'hFFFC_4000, 1'b0, 32'h0, 32'h0}
  };

  affine_2d_transform_unit_top #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // exact product, rounded to FRAC fraction bits with halves going up
  function automatic longint fx_mul(input longint a, input longint b);
    return (a * b + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input longint v);
    if (v > longint'(32'sh7FFF_FFFF))
      return 32'sh7FFF_FFFF;
    if (v < -longint'(32'sh7FFF_FFFF) - 1)
      return 32'sh8000_0000;
    return v[DATA_W-1:0];
  endfunction

  task automatic xform_identity();
    xform_m = '{32'sh0001_0000, 0, 0, 0, 32'sh0001_0000, 0};
  endtask

  // advance the matrix, or compute the mapped point, for one accepted transaction
  task automatic xform_apply(input kind_t k, input logic signed [31:0] a,
                             input logic signed [31:0] b, input logic signed [31:0] x,
                             input logic signed [31:0] y, output xy_t pt);
    longint one;
    longint t [MAT_N];
    longint s;
    logic signed [DATA_W-1:0] nm [MAT_N];
    one = longint'(1) <<< FRAC;
    t = '{one, 0, 0, 0, one, 0};
    pt = '{0, 0};
    case (k)
      KIND_POINT: begin
        pt.x = sat32(fx_mul(xform_m[0], x) + fx_mul(xform_m[1], y) + xform_m[2]);
        pt.y = sat32(fx_mul(xform_m[3], x) + fx_mul(xform_m[4], y) + xform_m[5]);
        return;
      end
      KIND_TRANSLATE: begin
        t[2] = a;
        t[5] = b;
      end
      KIND_ROTATE: begin
        t[0] = a;
        t[1] = -longint'(b);
        t[3] = b;
        t[4] = a;
      end
      KIND_SCALE: begin
        t[0] = a;
        t[4] = b;
      end
      KIND_SHEAR_X:   t[1] = a;
      KIND_REFLECT_X: t[4] = -one;
      KIND_REFLECT_Y: t[0] = -one;
      default: begin
        xform_identity();
        return;
      end
    endcase
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 3; j++) begin
        s = fx_mul(t[i*3], xform_m[j]) + fx_mul(t[i*3+1], xform_m[3+j]);
        if (j == 2)
          s += t[i*3+2];
        nm[i*3+j] = sat32(s);
      end
    end
    xform_m = nm;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic drive_item(input kind_t k, input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] x, input logic [31:0] y, input bit typed,
                            input logic [31:0] ex, input logic [31:0] ey);
    xy_t pt;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = k;
    s_axis_tdata  = {y, x, b, a};
    do
      @(posedge clk);
    while (!s_axis_tready);
    xform_apply(k, a, b, x, y, pt);
    if (k == KIND_POINT) begin
      if (typed)
        pt = '{ex, ey};
      point_results_q.push_back(pt);
    end
    @(negedge clk);
  endtask

  // mostly modest values so the matrix stays usable, with corners and full-range noise
  function automatic logic [31:0] rand_fx(input int unsigned span);
    int unsigned r;
    logic [31:0] corners [5];
    corners = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000, 32'hFFFF_0000};
    r = $urandom_range(99);
    if (r < 12)
      return $urandom;
    if (r < 20)
      return corners[$urandom_range(4)];
    return int'($urandom_range(2 * span, 0)) - int'(span);
  endfunction

  task automatic drive_random_item();
    int unsigned r;
    kind_t k;
    logic [31:0] a, b, x, y;
    r = $urandom_range(99);
    a = $urandom;
    b = $urandom;
    x = $urandom;
    y = $urandom;
    if (r < 40) begin
      k = KIND_POINT;
      x = rand_fx(32'h0010_0000);
      y = rand_fx(32'h0010_0000);
    end else if (r < 50) begin
      k = KIND_TRANSLATE;
      a = rand_fx(32'h0010_0000);
      b = rand_fx(32'h0010_0000);
    end else if (r < 62) begin
      k = KIND_ROTATE;
      a = rand_fx(32'h0001_0000);
      b = rand_fx(32'h0001_0000);
    end else if (r < 72) begin
      k = KIND_SCALE;
      a = rand_fx(32'h0002_0000);
      b = rand_fx(32'h0002_0000);
    end else if (r < 80) begin
      k = KIND_SHEAR_X;
      a = rand_fx(32'h0001_0000);
    end else if (r < 86) begin
      k = KIND_REFLECT_X;
    end else if (r < 92) begin
      k = KIND_REFLECT_Y;
    end else begin
      k = KIND_RESET;
    end
    drive_item(k, a, b, x, y, 1'b0, 32'h0, 32'h0);
  endtask

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : check_results
    xy_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (point_results_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: x=%h y=%h",
                                  m_axis_tdata[31:0], m_axis_tdata[63:32]));
      end else begin
        want = point_results_q.pop_front();
        if (m_axis_tdata[31:0] !== want.x)
          report_mismatch($sformatf("out_x got %h, want %h", m_axis_tdata[31:0], want.x));
        if (m_axis_tdata[63:32] !== want.y)
          report_mismatch($sformatf("out_y got %h, want %h", m_axis_tdata[63:32], want.y));
      end
    end
  end

  // end the run if no transaction moves on either side for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("[affine_2d_transform_unit_top] ERROR");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_POINT;
    xform_identity();
    repeat (RESET_CYC) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i])
      drive_item(dir_rows[i].kind, dir_rows[i].a, dir_rows[i].b, dir_rows[i].x,
                 dir_rows[i].y, dir_rows[i].typed, dir_rows[i].ex, dir_rows[i].ey);

    for (int ph = 0; ph < PHASES; ph++) begin
      src_idle_pct   = idle_tab[ph];
      sink_stall_pct = stall_tab[ph];
      repeat (RAND_ITEMS / PHASES) drive_random_item();
    end
    s_axis_tvalid = 1'b0;

    while (point_results_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (mismatch_count == 0)
      $display("[affine_2d_transform_unit_top] OK");
    else
      $display("[affine_2d_transform_unit_top] ERROR");
    $finish;
  end

endmodule

### affine_2d_transform_unit_top.f
src/affine2d_pkg.sv
src/affine_2d_transform_unit_top.sv
verif/tb_affine_2d_transform_unit_top.sv
